@@ rtl/lstri_pkg.sv @@
// Shared types, widths and latencies for the 2D least-squares trilateration block.
`default_nettype none
package lstri_pkg;

    localparam int COORD_W  = 20;
    localparam int DIST_W   = 19;
    localparam int RMS_W    = 20;
    localparam int IDX_W    = 3;
    localparam int N_ANCH   = 4;
    localparam int N_ROWS   = N_ANCH - 1;

    localparam int DIFF_W   = COORD_W + 1;
    localparam int KV_W     = 2 * COORD_W + 1;
    localparam int DSQ_W    = 2 * DIST_W;
    localparam int B_W      = KV_W + 1;
    localparam int PP_W     = 2 * DIFF_W;
    localparam int M_W      = PP_W + 1;
    localparam int V_W      = 64;
    localparam int MUL_W    = 64;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int HALF_W   = MUL_W / 2;
    localparam int NUM_W    = 106;
    localparam int DET_W    = 86;
    localparam int Q_W      = COORD_W;
    localparam int SQ_IN_W  = 46;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int E_W      = SQ_OUT_W + 1;

    localparam int MUL_LAT  = 3;
    localparam int DIV_LAT  = Q_W + 3;
    localparam int SQRT_LAT = SQ_OUT_W;
    localparam int D_DLY    = 2 * MUL_LAT + DIV_LAT + SQRT_LAT + 5;
    localparam int P_DLY    = 2 * SQRT_LAT + 5;
    localparam int CFG_SETTLE = MUL_LAT + 6;
    localparam int SETTLE_W = $clog2(CFG_SETTLE + 1);

    localparam int POS_MAX  = 2 ** (COORD_W - 1) - 1;
    localparam int NEG_MAG  = 2 ** (COORD_W - 1);
    localparam int RMS_MAX  = 2 ** RMS_W - 1;

    typedef enum logic [IDX_W-1:0] {
        REG_A0X = 3'd0,
        REG_A0Y = 3'd1,
        REG_A1X = 3'd2,
        REG_A1Y = 3'd3,
        REG_A2X = 3'd4,
        REG_A2Y = 3'd5,
        REG_A3X = 3'd6,
        REG_A3Y = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist0;
        logic [DIST_W-1:0] dist1;
        logic [DIST_W-1:0] dist2;
        logic [DIST_W-1:0] dist3;
    } lstri_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [RMS_W-1:0]          residual_rms;
        logic                      singular;
    } lstri_out_t;

endpackage
`default_nettype wire

@@ rtl/least_squares_trilateration_2d.sv @@
// 2D least-squares trilateration from four anchor distances, fully pipelined.
// Throughput: one beat per cycle; the whole pipeline holds while the result is not taken.
// Geometry terms (differences, normal matrix, determinant) are rebuilt from the anchor
// registers; s_ready stays low after reset and after every register write until the settle counter has run down.
// Reset clears anchors to zero and empties the pipeline.
`default_nettype none
module least_squares_trilateration_2d (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire lstri_pkg::lstri_in_t                  s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output lstri_pkg::lstri_out_t                      m_data,
    input  wire logic                                  cfg_we,
    input  wire logic [lstri_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [lstri_pkg::COORD_W-1:0]         cfg_data
);
    localparam int NA  = lstri_pkg::N_ANCH;
    localparam int NR  = lstri_pkg::N_ROWS;
    localparam int CW  = lstri_pkg::COORD_W;
    localparam int DIW = lstri_pkg::DIFF_W;
    localparam int MW  = lstri_pkg::MUL_W;
    localparam int PW  = lstri_pkg::PROD_W;
    localparam int SIW = lstri_pkg::SQ_IN_W;
    localparam int SOW = lstri_pkg::SQ_OUT_W;
    localparam int EW  = lstri_pkg::E_W;

    // anchor registers and derived geometry
    logic signed [CW-1:0]                   ax_reg [NA];
    logic signed [CW-1:0]                   ay_reg [NA];
    logic signed [lstri_pkg::KV_W-1:0]      kv_reg [NA];
    logic signed [DIW-1:0]                  adx_reg [NR];
    logic signed [DIW-1:0]                  ady_reg [NR];
    logic signed [lstri_pkg::B_W-1:0]       kd_reg [NR];
    logic signed [lstri_pkg::PP_W-1:0]      pxx_reg [NR];
    logic signed [lstri_pkg::PP_W-1:0]      pxy_reg [NR];
    logic signed [lstri_pkg::PP_W-1:0]      pyy_reg [NR];
    logic signed [lstri_pkg::M_W-1:0]       m00_reg, m01_reg, m11_reg;
    logic signed [PW-1:0]                   pdet_a, pdet_b;
    logic signed [lstri_pkg::DET_W-1:0]     det_reg;
    logic                                   singular_reg;
    logic [lstri_pkg::SETTLE_W-1:0]         settle_reg;

    logic                                   en, accept;

    logic [lstri_pkg::DIST_W-1:0]           din [NA];
    logic [lstri_pkg::DIST_W-1:0]           dlate [NA];
    logic                                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic                                   v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    lstri_pkg::lstri_in_t                   d1_reg;
    logic [lstri_pkg::DSQ_W-1:0]            dsq1_reg [NA];
    logic signed [lstri_pkg::B_W-1:0]       b2_reg [NR];
    logic signed [PW-1:0]                   prx [NR];
    logic signed [PW-1:0]                   pry [NR];
    logic                                   mul1_vld;
    logic signed [lstri_pkg::V_W-1:0]       vx_reg, vy_reg;
    logic signed [PW-1:0]                   pn [4];
    logic                                   mul2_vld;
    logic signed [lstri_pkg::NUM_W-1:0]     nx_reg, ny_reg;
    logic                                   divx_vld;
    logic signed [CW-1:0]                   px, py;
    logic signed [DIW-1:0]                  dx [NA];
    logic signed [DIW-1:0]                  dy [NA];
    logic signed [2*DIW-1:0]                dxx [NA];
    logic signed [2*DIW-1:0]                dyy [NA];
    logic [2*DIW-1:0]                       sqx_reg [NA];
    logic [2*DIW-1:0]                       sqy_reg [NA];
    logic [SIW-1:0]                         s_reg [NA];
    logic                                   sq1_vld [NA];
    logic [SOW-1:0]                         root1 [NA];
    logic                                   rnd1 [NA];
    logic signed [EW-1:0]                   e_reg [NA];
    logic signed [2*EW-1:0]                 ee [NA];
    logic [SIW-1:0]                         esq_reg [NA];
    logic [SIW-1:0]                         sum_reg;
    logic                                   sq2_vld;
    logic [SOW-1:0]                         root2;
    logic [SOW:0]                           rms_full;

    lstri_pkg::lstri_in_t                   d_dly_reg [lstri_pkg::D_DLY];
    logic signed [CW-1:0]                   px_dly_reg [lstri_pkg::P_DLY];
    logic signed [CW-1:0]                   py_dly_reg [lstri_pkg::P_DLY];

    logic                                   m_valid_reg;
    lstri_pkg::lstri_out_t                  m_data_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NA; i++) begin
                ax_reg[i] <= '0;
                ay_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (lstri_pkg::reg_idx_t'(cfg_index))
                lstri_pkg::REG_A0X: ax_reg[0] <= $signed(cfg_data);
                lstri_pkg::REG_A0Y: ay_reg[0] <= $signed(cfg_data);
                lstri_pkg::REG_A1X: ax_reg[1] <= $signed(cfg_data);
                lstri_pkg::REG_A1Y: ay_reg[1] <= $signed(cfg_data);
                lstri_pkg::REG_A2X: ax_reg[2] <= $signed(cfg_data);
                lstri_pkg::REG_A2Y: ay_reg[2] <= $signed(cfg_data);
                lstri_pkg::REG_A3X: ax_reg[3] <= $signed(cfg_data);
                lstri_pkg::REG_A3Y: ay_reg[3] <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            settle_reg <= lstri_pkg::SETTLE_W'(lstri_pkg::CFG_SETTLE);
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    // geometry chain, free running
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NA; i++) begin
            kv_reg[i] <= lstri_pkg::KV_W'(ax_reg[i]) * lstri_pkg::KV_W'(ax_reg[i])
                       + lstri_pkg::KV_W'(ay_reg[i]) * lstri_pkg::KV_W'(ay_reg[i]);
        end
        for (int k = 0; k < NR; k++) begin
            adx_reg[k] <= DIW'(ax_reg[k+1]) - DIW'(ax_reg[0]);
            ady_reg[k] <= DIW'(ay_reg[k+1]) - DIW'(ay_reg[0]);
            kd_reg[k]  <= lstri_pkg::B_W'(kv_reg[k+1]) - lstri_pkg::B_W'(kv_reg[0]);
            pxx_reg[k] <= lstri_pkg::PP_W'(adx_reg[k]) * lstri_pkg::PP_W'(adx_reg[k]);
            pxy_reg[k] <= lstri_pkg::PP_W'(adx_reg[k]) * lstri_pkg::PP_W'(ady_reg[k]);
            pyy_reg[k] <= lstri_pkg::PP_W'(ady_reg[k]) * lstri_pkg::PP_W'(ady_reg[k]);
        end
        m00_reg <= lstri_pkg::M_W'(pxx_reg[0]) + lstri_pkg::M_W'(pxx_reg[1])
                 + lstri_pkg::M_W'(pxx_reg[2]);
        m01_reg <= lstri_pkg::M_W'(pxy_reg[0]) + lstri_pkg::M_W'(pxy_reg[1])
                 + lstri_pkg::M_W'(pxy_reg[2]);
        m11_reg <= lstri_pkg::M_W'(pyy_reg[0]) + lstri_pkg::M_W'(pyy_reg[1])
                 + lstri_pkg::M_W'(pyy_reg[2]);
        det_reg      <= lstri_pkg::DET_W'(pdet_a - pdet_b);
        singular_reg <= (det_reg == '0);
    end

    lstri_mul u_det_a (
        .aclk(aclk), .aresetn(aresetn), .en(1'b1), .in_valid(1'b1),
        .in_a(MW'(m00_reg)), .in_b(MW'(m11_reg)), .out_valid(), .out_p(pdet_a)
    );
    lstri_mul u_det_b (
        .aclk(aclk), .aresetn(aresetn), .en(1'b1), .in_valid(1'b1),
        .in_a(MW'(m01_reg)), .in_b(MW'(m01_reg)), .out_valid(), .out_p(pdet_b)
    );

    // handshake
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && (settle_reg == '0);
    assign accept  = s_valid && s_ready;

    assign din[0] = s_data.dist0;
    assign din[1] = s_data.dist1;
    assign din[2] = s_data.dist2;
    assign din[3] = s_data.dist3;

    assign dlate[0] = d_dly_reg[lstri_pkg::D_DLY-1].dist0;
    assign dlate[1] = d_dly_reg[lstri_pkg::D_DLY-1].dist1;
    assign dlate[2] = d_dly_reg[lstri_pkg::D_DLY-1].dist2;
    assign dlate[3] = d_dly_reg[lstri_pkg::D_DLY-1].dist3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= accept;
            v2_reg      <= v1_reg;
            v3_reg      <= mul1_vld;
            v4_reg      <= mul2_vld;
            v5_reg      <= divx_vld;
            v6_reg      <= v5_reg;
            v7_reg      <= sq1_vld[0];
            v8_reg      <= v7_reg;
            v9_reg      <= v8_reg;
            m_valid_reg <= sq2_vld;
        end
    end

    // right-hand sides
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg <= s_data;
            for (int i = 0; i < NA; i++) begin
                dsq1_reg[i] <= lstri_pkg::DSQ_W'(din[i]) * lstri_pkg::DSQ_W'(din[i]);
            end
            for (int k = 0; k < NR; k++) begin
                b2_reg[k] <= $signed(lstri_pkg::B_W'(dsq1_reg[0]))
                           - $signed(lstri_pkg::B_W'(dsq1_reg[k+1])) + kd_reg[k];
            end
        end
    end

    // A transpose b
    for (genvar k = 0; k < NR; k++) begin : g_atb
        lstri_mul u_mx (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
            .in_a(MW'(adx_reg[k])), .in_b(MW'(b2_reg[k])),
            .out_valid(), .out_p(prx[k])
        );
        lstri_mul u_my (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
            .in_a(MW'(ady_reg[k])), .in_b(MW'(b2_reg[k])),
            .out_valid(), .out_p(pry[k])
        );
    end

    lstri_mul u_vld1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .in_a('0), .in_b('0), .out_valid(mul1_vld), .out_p()
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg <= lstri_pkg::V_W'(prx[0]) + lstri_pkg::V_W'(prx[1])
                    + lstri_pkg::V_W'(prx[2]);
            vy_reg <= lstri_pkg::V_W'(pry[0]) + lstri_pkg::V_W'(pry[1])
                    + lstri_pkg::V_W'(pry[2]);
        end
    end

    // adjoint times A transpose b
    lstri_mul u_n0 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg),
        .in_a(MW'(m11_reg)), .in_b(vx_reg), .out_valid(mul2_vld), .out_p(pn[0])
    );
    lstri_mul u_n1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg),
        .in_a(MW'(m01_reg)), .in_b(vy_reg), .out_valid(), .out_p(pn[1])
    );
    lstri_mul u_n2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg),
        .in_a(MW'(m00_reg)), .in_b(vy_reg), .out_valid(), .out_p(pn[2])
    );
    lstri_mul u_n3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg),
        .in_a(MW'(m01_reg)), .in_b(vx_reg), .out_valid(), .out_p(pn[3])
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= lstri_pkg::NUM_W'(pn[0] - pn[1]);
            ny_reg <= lstri_pkg::NUM_W'(pn[2] - pn[3]);
        end
    end

    lstri_div u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v4_reg),
        .in_num(nx_reg), .in_det(det_reg), .out_valid(divx_vld), .out_coord(px)
    );
    lstri_div u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v4_reg),
        .in_num(ny_reg), .in_det(det_reg), .out_valid(), .out_coord(py)
    );

    // distances from the solution
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            dx[i]  = DIW'(ax_reg[i]) - DIW'(px);
            dy[i]  = DIW'(ay_reg[i]) - DIW'(py);
            dxx[i] = (2*DIW)'(dx[i]) * (2*DIW)'(dx[i]);
            dyy[i] = (2*DIW)'(dy[i]) * (2*DIW)'(dy[i]);
            ee[i]  = (2*EW)'(e_reg[i]) * (2*EW)'(e_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                sqx_reg[i] <= $unsigned(dxx[i]);
                sqy_reg[i] <= $unsigned(dyy[i]);
                s_reg[i]   <= SIW'(sqx_reg[i]) + SIW'(sqy_reg[i]);
            end
        end
    end

    for (genvar i = 0; i < NA; i++) begin : g_dist
        lstri_sqrt u_sqrt (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v6_reg),
            .in_value(s_reg[i]), .out_valid(sq1_vld[i]),
            .out_root(root1[i]), .out_rnd(rnd1[i])
        );
    end

    // residuals
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                e_reg[i] <= $signed(EW'(dlate[i])) - $signed(EW'(root1[i]))
                          - $signed(EW'(rnd1[i]));
                esq_reg[i] <= SIW'($unsigned(ee[i]));
            end
            sum_reg <= esq_reg[0] + esq_reg[1] + esq_reg[2] + esq_reg[3];
        end
    end

    lstri_sqrt u_sqrt_rms (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v9_reg),
        .in_value(sum_reg), .out_valid(sq2_vld), .out_root(root2), .out_rnd()
    );

    // sideband delay lines
    always_ff @(posedge aclk) begin
        if (en) begin
            d_dly_reg[0]  <= d1_reg;
            px_dly_reg[0] <= px;
            py_dly_reg[0] <= py;
            for (int i = 1; i < lstri_pkg::D_DLY; i++) begin
                d_dly_reg[i] <= d_dly_reg[i-1];
            end
            for (int i = 1; i < lstri_pkg::P_DLY; i++) begin
                px_dly_reg[i] <= px_dly_reg[i-1];
                py_dly_reg[i] <= py_dly_reg[i-1];
            end
        end
    end

    // output beat
    assign rms_full = ((SOW+1)'(root2) + 1'b1) >> 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (singular_reg) begin
                m_data_reg.pos_x        <= '0;
                m_data_reg.pos_y        <= '0;
                m_data_reg.residual_rms <= '0;
                m_data_reg.singular     <= 1'b1;
            end else begin
                m_data_reg.pos_x <= px_dly_reg[lstri_pkg::P_DLY-1];
                m_data_reg.pos_y <= py_dly_reg[lstri_pkg::P_DLY-1];
                if (rms_full > (SOW+1)'(lstri_pkg::RMS_MAX)) begin
                    m_data_reg.residual_rms <= lstri_pkg::RMS_W'(lstri_pkg::RMS_MAX);
                end else begin
                    m_data_reg.residual_rms <= lstri_pkg::RMS_W'(rms_full);
                end
                m_data_reg.singular <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire

@@ rtl/lstri_mul.sv @@
// Three-stage signed 64x64 multiplier built from four 32x32 partial products.
`default_nettype none
module lstri_mul (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire logic signed [lstri_pkg::MUL_W-1:0]    in_a,
    input  wire logic signed [lstri_pkg::MUL_W-1:0]    in_b,
    output logic                                       out_valid,
    output logic signed [lstri_pkg::PROD_W-1:0]        out_p
);
    localparam int W = lstri_pkg::MUL_W;
    localparam int H = lstri_pkg::HALF_W;
    localparam int P = lstri_pkg::PROD_W;

    logic [2:0]     vld_reg;
    logic           neg1_reg, neg2_reg;
    logic [W-1:0]   ma_reg, mb_reg;
    logic [W-1:0]   pp0_reg, pp1_reg, pp2_reg, pp3_reg;
    logic [P-1:0]   sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_comb begin
        sum = (P'(pp3_reg) << W) + (P'(pp1_reg) << H) + (P'(pp2_reg) << H) + P'(pp0_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= in_a[W-1] ^ in_b[W-1];
            ma_reg   <= in_a[W-1] ? W'(-in_a) : W'(in_a);
            mb_reg   <= in_b[W-1] ? W'(-in_b) : W'(in_b);
            neg2_reg <= neg1_reg;
            pp0_reg  <= W'(ma_reg[H-1:0]) * W'(mb_reg[H-1:0]);
            pp1_reg  <= W'(ma_reg[H-1:0]) * W'(mb_reg[W-1:H]);
            pp2_reg  <= W'(ma_reg[W-1:H]) * W'(mb_reg[H-1:0]);
            pp3_reg  <= W'(ma_reg[W-1:H]) * W'(mb_reg[W-1:H]);
            out_p    <= neg2_reg ? $signed(P'(-sum)) : $signed(sum);
        end
    end

    assign out_valid = vld_reg[2];
endmodule
`default_nettype wire

@@ rtl/lstri_div.sv @@
// Pipelined rounding divider: round(num / (2*det)) saturated to a 20-bit coordinate.
`default_nettype none
module lstri_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire logic signed [lstri_pkg::NUM_W-1:0]    in_num,
    input  wire logic signed [lstri_pkg::DET_W-1:0]    in_det,
    output logic                                       out_valid,
    output logic signed [lstri_pkg::COORD_W-1:0]       out_coord
);
    localparam int NW = lstri_pkg::NUM_W;
    localparam int DW = lstri_pkg::DET_W;
    localparam int QW = lstri_pkg::Q_W;
    localparam int CW = lstri_pkg::COORD_W;

    logic           vld_p_reg, neg_p_reg;
    logic [NW-1:0]  n_p_reg;
    logic [DW-1:0]  dd_p_reg;

    logic [QW:0]    vld_reg;
    logic           neg_reg [QW+1];
    logic           sat_reg [QW+1];
    logic [NW-1:0]  rem_reg [QW+1];
    logic [DW-1:0]  dd_reg  [QW+1];
    logic [QW-1:0]  q_reg   [QW+1];

    logic [NW-1:0]  rem_next [QW+1];
    logic [QW-1:0]  q_next   [QW+1];
    logic           out_vld_reg;

    always_comb begin
        logic [NW-1:0] trial;
        rem_next[0] = n_p_reg;
        q_next[0]   = '0;
        for (int j = 1; j <= QW; j++) begin
            trial = NW'(dd_reg[j-1]) << (QW - j);
            if (rem_reg[j-1] >= trial) begin
                rem_next[j] = rem_reg[j-1] - trial;
                q_next[j]   = q_reg[j-1] | (QW'(1) << (QW - j));
            end else begin
                rem_next[j] = rem_reg[j-1];
                q_next[j]   = q_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_p_reg   <= 1'b0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_p_reg   <= in_valid;
            vld_reg     <= {vld_reg[QW-1:0], vld_p_reg};
            out_vld_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_p_reg <= in_num[NW-1];
            n_p_reg   <= (in_num[NW-1] ? NW'(-in_num) : NW'(in_num))
                         + NW'($unsigned(in_det));
            dd_p_reg  <= DW'($unsigned(in_det)) << 1;

            neg_reg[0] <= neg_p_reg;
            sat_reg[0] <= n_p_reg >= (NW'(dd_p_reg) << QW);
            dd_reg[0]  <= dd_p_reg;
            for (int j = 0; j <= QW; j++) begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
            end
            for (int j = 1; j <= QW; j++) begin
                neg_reg[j] <= neg_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
                dd_reg[j]  <= dd_reg[j-1];
            end

            if (neg_reg[QW]) begin
                if (sat_reg[QW] || ((QW+1)'(q_reg[QW]) > (QW+1)'(lstri_pkg::NEG_MAG))) begin
                    out_coord <= {1'b1, {(CW-1){1'b0}}};
                end else begin
                    out_coord <= CW'(-$signed({1'b0, q_reg[QW]}));
                end
            end else begin
                if (sat_reg[QW] || ((QW+1)'(q_reg[QW]) > (QW+1)'(lstri_pkg::POS_MAX))) begin
                    out_coord <= {1'b0, {(CW-1){1'b1}}};
                end else begin
                    out_coord <= $signed(CW'(q_reg[QW]));
                end
            end
        end
    end

    assign out_valid = out_vld_reg;
endmodule
`default_nettype wire

@@ rtl/lstri_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with round-to-nearest flag.
`default_nettype none
module lstri_sqrt (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [lstri_pkg::SQ_IN_W-1:0]     in_value,
    output logic                                   out_valid,
    output logic [lstri_pkg::SQ_OUT_W-1:0]         out_root,
    output logic                                   out_rnd
);
    localparam int IW = lstri_pkg::SQ_IN_W;
    localparam int OW = lstri_pkg::SQ_OUT_W;

    logic [OW-1:0]  vld_reg;
    logic [IW-1:0]  rem_reg  [OW];
    logic [OW-1:0]  res_reg  [OW];
    logic [IW-1:0]  src_rem  [OW];
    logic [OW-1:0]  src_res  [OW];
    logic [IW-1:0]  rem_next [OW];
    logic [OW-1:0]  res_next [OW];

    always_comb begin
        logic [IW+1:0] trial;
        src_rem[0] = in_value;
        src_res[0] = '0;
        for (int g = 1; g < OW; g++) begin
            src_rem[g] = rem_reg[g-1];
            src_res[g] = res_reg[g-1];
        end
        for (int g = 0; g < OW; g++) begin
            trial = ((IW+2)'(src_res[g]) << (OW - g)) | ((IW+2)'(1) << (2 * (OW - 1 - g)));
            if ((IW+2)'(src_rem[g]) >= trial) begin
                rem_next[g] = IW'((IW+2)'(src_rem[g]) - trial);
                res_next[g] = src_res[g] | (OW'(1) << (OW - 1 - g));
            end else begin
                rem_next[g] = src_rem[g];
                res_next[g] = src_res[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[OW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < OW; g++) begin
                rem_reg[g] <= rem_next[g];
                res_reg[g] <= res_next[g];
            end
        end
    end

    assign out_valid = vld_reg[OW-1];
    assign out_root  = res_reg[OW-1];
    assign out_rnd   = rem_reg[OW-1] > IW'(res_reg[OW-1]);
endmodule
`default_nettype wire

@@ sim/least_squares_trilateration_2d_tb.sv @@
// Testbench for the 2D least-squares trilateration block: predicts each beat and checks it.
`timescale 1ns / 100ps
module least_squares_trilateration_2d_tb;
    import lstri_pkg::*;

    localparam int WDOG_LIMIT = 5000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    lstri_in_t           s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    lstri_out_t          m_data;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [COORD_W-1:0]  cfg_data = '0;

    least_squares_trilateration_2d u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    longint     anc_x[N_ANCH];
    longint     anc_y[N_ANCH];
    lstri_in_t  dist_q[$];
    lstri_out_t fix_q[$];
    int         tx_idle = 22;
    int         rx_idle = 22;
    bit         hold_tx = 1'b0;
    int         n_sent = 0;
    int         n_fixes = 0;
    int         n_singular = 0;
    int         n_err = 0;
    int         quiet_cycles = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_coord(logic signed [127:0] num, logic [127:0] det);
        logic [127:0] mag, q;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag + det) / (det << 1);
        if (neg) return (q > NEG_MAG) ? -longint'(NEG_MAG) : -longint'(q);
        return (q > POS_MAX) ? longint'(POS_MAX) : longint'(q);
    endfunction

    function automatic lstri_out_t solve_position(lstri_in_t it);
        longint dd[N_ANCH], kv[N_ANCH];
        longint da, db, bb, m00, m01, m11, v0, v1, px, py, ex, ey, e;
        logic signed [127:0] w00, w01, w11, wv0, wv1, det, nx, ny;
        longint unsigned s, rt, sumsq, rms;
        lstri_out_t r;
        dd[0] = it.dist0;
        dd[1] = it.dist1;
        dd[2] = it.dist2;
        dd[3] = it.dist3;
        for (int i = 0; i < N_ANCH; i++) kv[i] = anc_x[i] * anc_x[i] + anc_y[i] * anc_y[i];
        m00 = 0; m01 = 0; m11 = 0; v0 = 0; v1 = 0;
        for (int k = 1; k < N_ANCH; k++) begin
            da = anc_x[k] - anc_x[0];
            db = anc_y[k] - anc_y[0];
            bb = dd[0] * dd[0] - dd[k] * dd[k] + kv[k] - kv[0];
            m00 += da * da;
            m01 += da * db;
            m11 += db * db;
            v0  += da * bb;
            v1  += db * bb;
        end
        w00 = m00; w01 = m01; w11 = m11; wv0 = v0; wv1 = v1;
        det = w00 * w11 - w01 * w01;
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        nx = w11 * wv0 - w01 * wv1;
        ny = w00 * wv1 - w01 * wv0;
        px = round_coord(nx, det);
        py = round_coord(ny, det);
        sumsq = 0;
        for (int i = 0; i < N_ANCH; i++) begin
            ex = anc_x[i] - px;
            ey = anc_y[i] - py;
            s = ex * ex + ey * ey;
            rt = int_sqrt(s);
            if (s - rt * rt > rt) rt++;
            e = dd[i] - longint'(rt);
            sumsq += e * e;
        end
        rms = (int_sqrt(sumsq) + 1) >> 1;
        if (rms > RMS_MAX) rms = RMS_MAX;
        r.pos_x = px[COORD_W-1:0];
        r.pos_y = py[COORD_W-1:0];
        r.residual_rms = rms[RMS_W-1:0];
        return r;
    endfunction

    // distances from a chosen point, with optional noise, clamped to the field
    function automatic lstri_in_t ranges_from(longint px, longint py, int noise);
        longint dv[N_ANCH];
        lstri_in_t it;
        for (int i = 0; i < N_ANCH; i++) begin
            dv[i] = longint'(int_sqrt((anc_x[i] - px) * (anc_x[i] - px)
                                      + (anc_y[i] - py) * (anc_y[i] - py)));
            dv[i] += longint'($urandom_range(2 * noise)) - noise;
            if (dv[i] < 0) dv[i] = 0;
            if (dv[i] > 2 ** DIST_W - 1) dv[i] = 2 ** DIST_W - 1;
        end
        it.dist0 = dv[0][DIST_W-1:0];
        it.dist1 = dv[1][DIST_W-1:0];
        it.dist2 = dv[2][DIST_W-1:0];
        it.dist3 = dv[3][DIST_W-1:0];
        return it;
    endfunction

    function automatic lstri_in_t raw_ranges();
        lstri_in_t it;
        it.dist0 = DIST_W'($urandom);
        it.dist1 = DIST_W'($urandom);
        it.dist2 = DIST_W'($urandom);
        it.dist3 = DIST_W'($urandom);
        return it;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                fix_q.push_back(solve_position(s_data));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (dist_q.size() > 0 && !hold_tx && $urandom_range(99) >= tx_idle) begin
                    s_valid <= 1'b1;
                    s_data  <= dist_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        lstri_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= rx_idle;
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_valid && m_ready) begin
                if (fix_q.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $realtime, m_data);
                    n_err++;
                end else begin
                    want = fix_q.pop_front();
                    n_fixes++;
                    if (want.singular) n_singular++;
                    if (m_data.pos_x !== want.pos_x) begin
                        $display("%0t: pos_x exp %0d got %0d", $realtime, want.pos_x,
                                 m_data.pos_x);
                        n_err++;
                    end
                    if (m_data.pos_y !== want.pos_y) begin
                        $display("%0t: pos_y exp %0d got %0d", $realtime, want.pos_y,
                                 m_data.pos_y);
                        n_err++;
                    end
                    if (m_data.residual_rms !== want.residual_rms) begin
                        $display("%0t: residual_rms exp %0d got %0d", $realtime,
                                 want.residual_rms, m_data.residual_rms);
                        n_err++;
                    end
                    if (m_data.singular !== want.singular) begin
                        $display("%0t: singular exp %0b got %0b", $realtime, want.singular,
                                 m_data.singular);
                        n_err++;
                    end
                end
            end
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                         fix_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic drain();
        while (dist_q.size() > 0 || s_valid || fix_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_anchors(longint xs[N_ANCH], longint ys[N_ANCH]);
        reg_idx_t idx;
        for (int i = 0; i < 2 * N_ANCH; i++) begin
            idx = reg_idx_t'(i);
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (i % 2) ? ys[i/2][COORD_W-1:0] : xs[i/2][COORD_W-1:0];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        for (int i = 0; i < N_ANCH; i++) begin
            anc_x[i] = xs[i];
            anc_y[i] = ys[i];
        end
    endtask

    task automatic directed_ranges();
        dist_q.push_back('0);
        dist_q.push_back('1);
        dist_q.push_back({19'h7FFFF, 19'd0, 19'h7FFFF, 19'd0});
        dist_q.push_back({19'd0, 19'h7FFFF, 19'd0, 19'h7FFFF});
        dist_q.push_back(ranges_from(0, 0, 0));
        dist_q.push_back(raw_ranges());
    endtask

    function automatic longint rand_coord(bit wide);
        logic [COORD_W-1:0] v;
        if (wide) begin
            v = COORD_W'($urandom);
            return longint'($signed(v));
        end
        return longint'($urandom_range(200000)) - 100000;
    endfunction

    initial begin
        longint xs[N_ANCH], ys[N_ANCH];
        bit wide;
        for (int i = 0; i < N_ANCH; i++) begin
            anc_x[i] = 0;
            anc_y[i] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // all anchors at origin after reset: singular
        directed_ranges();
        drain();

        xs = '{-5000, 5000, 5000, -5000};
        ys = '{-5000, -5000, 5000, 5000};
        set_anchors(xs, ys);
        directed_ranges();
        dist_q.push_back(ranges_from(1234, -777, 0));
        dist_q.push_back(ranges_from(400000, 400000, 3));
        drain();

        xs = '{-524288, 524287, 524287, -524288};
        ys = '{-524288, -524288, 524287, 524287};
        set_anchors(xs, ys);
        directed_ranges();
        drain();

        // collinear anchors: singular with nonzero geometry
        xs = '{0, 1000, 2000, -5000};
        ys = '{0, 1000, 2000, -5000};
        set_anchors(xs, ys);
        directed_ranges();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                tx_idle = 0;
                rx_idle = 0;
            end else begin
                tx_idle = 22;
                rx_idle = 22;
            end
            wide = (ph % 3) == 0;
            for (int i = 0; i < N_ANCH; i++) begin
                xs[i] = rand_coord(wide);
                ys[i] = rand_coord(wide);
            end
            set_anchors(xs, ys);
            for (int n = 0; n < 130; n++) begin
                if ($urandom_range(99) < 70)
                    dist_q.push_back(ranges_from(rand_coord(wide), rand_coord(wide),
                                                 $urandom_range(50)));
                else
                    dist_q.push_back(raw_ranges());
            end
            if (ph == 4) begin
                while (dist_q.size() > 65) @(posedge aclk);
                hold_tx = 1'b1;
                while (s_valid || fix_q.size() > 0) @(posedge aclk);
                hold_tx = 1'b0;
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        $display("Sent %0d distance sets over 10 anchor layouts; checked %0d fixes",
                 n_sent, n_fixes);
        $display("(%0d singular). Mismatches: %0d, results left unmatched: %0d",
                 n_singular, n_err, fix_q.size());
        if (n_err == 0 && fix_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lstri_pkg.sv
rtl/lstri_mul.sv
rtl/lstri_div.sv
rtl/lstri_sqrt.sv
rtl/least_squares_trilateration_2d.sv
sim/least_squares_trilateration_2d_tb.sv
